// ----- src/box_sweep_convex_brush_clip_top_macros.svh -----
`ifndef BOX_SWEEP_CONVEX_BRUSH_CLIP_TOP_MACROS_SVH
`define BOX_SWEEP_CONVEX_BRUSH_CLIP_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSCBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bscbc assertion failed");

// next-cycle implication, disabled during reset
`define BSCBC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bscbc assertion failed");

`endif

// ----- src/bscbc_pkg.sv -----
package bscbc_pkg;

   // normal format Q2.14
   localparam int NORM_W    = 16;
   localparam int NORM_FRAC = 14;

   // clip epsilon register
   localparam int              EPS_W     = 16;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd8;

   // eps * (n.n) product width, also the margin divider step count
   localparam int EPW = 48;

   // register file index
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EPS   = 3'd0,
      CSR_MIN_X = 3'd1,
      CSR_MIN_Y = 3'd2,
      CSR_MIN_Z = 3'd3,
      CSR_MAX_X = 3'd4,
      CSR_MAX_Y = 3'd5,
      CSR_MAX_Z = 3'd6
   } csr_index_type;

endpackage

// ----- src/bscbc_req_if.sv -----
interface bscbc_req_if import bscbc_pkg::*; #(
   parameter int COORD_WIDTH = 24
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] start_z;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic signed [COORD_WIDTH-1:0] end_z;
   logic signed [NORM_W-1:0]      normal_x;
   logic signed [NORM_W-1:0]      normal_y;
   logic signed [NORM_W-1:0]      normal_z;
   logic signed [COORD_WIDTH-1:0] plane_distance;
   logic                          last_plane;

   modport source (
      output valid, start_x, start_y, start_z, end_x, end_y, end_z,
             normal_x, normal_y, normal_z, plane_distance, last_plane,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
             normal_x, normal_y, normal_z, plane_distance, last_plane,
      output ready
   );
endinterface

// ----- src/bscbc_rsp_if.sv -----
interface bscbc_rsp_if import bscbc_pkg::*; #(
   parameter int COORD_WIDTH   = 24,
   parameter int FRACTION_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic [FRACTION_BITS:0]        fraction;
   logic                          start_solid;
   logic                          all_solid;
   logic signed [NORM_W-1:0]      hit_normal_x;
   logic signed [NORM_W-1:0]      hit_normal_y;
   logic signed [NORM_W-1:0]      hit_normal_z;
   logic signed [COORD_WIDTH-1:0] hit_distance;
   logic signed [COORD_WIDTH-1:0] stop_x;
   logic signed [COORD_WIDTH-1:0] stop_y;
   logic signed [COORD_WIDTH-1:0] stop_z;

   modport source (
      output valid, fraction, start_solid, all_solid, hit_normal_x, hit_normal_y,
             hit_normal_z, hit_distance, stop_x, stop_y, stop_z,
      input  ready
   );
   modport sink (
      input  valid, fraction, start_solid, all_solid, hit_normal_x, hit_normal_y,
             hit_normal_z, hit_distance, stop_x, stop_y, stop_z,
      output ready
   );
endinterface

// ----- src/box_sweep_convex_brush_clip_top.sv -----
// Until the brush is fully in front, a plane runs the bit-serial products, the 48-step
//   margin divider (not for a zero normal), the distance and decision steps and, if it
//   crosses, the fraction divider; a final plane adds the stop point and result load.
// Throughput: one request at a time; ready is high only while waiting for a request.
// Reset (synchronous, active high) clears the brush state, loads register defaults
//   and drops the result valid; no clearing pass.
`include "box_sweep_convex_brush_clip_top_macros.svh"

module box_sweep_convex_brush_clip_top import bscbc_pkg::*; #(
   parameter int COORD_WIDTH   = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0] csr_write_data,
   bscbc_req_if.sink              req_bus,
   bscbc_rsp_if.source            rsp_bus
);

   localparam int CW      = COORD_WIDTH;
   localparam int FB      = FRACTION_BITS;
   localparam int DW      = CW + 20;
   localparam int FW      = FB + 2;
   localparam int SW      = CW + FB + 2;
   localparam int CNT_MAX = (EPW > FB + 1) ? EPW : FB + 1;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam logic signed [FW-1:0] F_ONE  = {2'b01, {FB{1'b0}}};
   localparam logic signed [FW-1:0] F_MONE = {2'b11, {FB{1'b0}}};

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_MUL  = 12'b0000_0000_0010,
      ST_EPS  = 12'b0000_0000_0100,
      ST_DIVE = 12'b0000_0000_1000,
      ST_DIST = 12'b0000_0001_0000,
      ST_DIFF = 12'b0000_0010_0000,
      ST_DEC  = 12'b0000_0100_0000,
      ST_DIVF = 12'b0000_1000_0000,
      ST_UPD  = 12'b0001_0000_0000,
      ST_FIN  = 12'b0010_0000_0000,
      ST_STOP = 12'b0100_0000_0000,
      ST_OUT  = 12'b1000_0000_0000
   } state_type;

   function automatic logic signed [DW-1:0] pp_term(input logic signed [DW-1:0] x,
                                                    input logic b, input logic neg);
      pp_term = b ? (neg ? -x : x) : '0;
   endfunction

   // configuration registers
   logic [EPS_W-1:0]       eps_ff;
   logic signed [CW-1:0]   hmin_ff [3];
   logic signed [CW-1:0]   hmax_ff [3];

   // request capture
   logic signed [CW-1:0]     s_ff [3];
   logic signed [CW-1:0]     e_ff [3];
   logic signed [NORM_W-1:0] n_ff [3];
   logic signed [CW-1:0]     pd_ff;
   logic                     last_ff;

   // sequencer
   state_type        state_ff;
   logic [1:0]       axis_ff;
   logic [CNT_W-1:0] cnt_ff;

   // bit-serial dot products
   logic [NORM_W-1:0]    mb_ff;
   logic signed [DW-1:0] mn_ff, mc_ff, ms_ff, me_ff;
   logic signed [DW-1:0] nn_ff, exp_ff, ds_ff, de_ff;
   logic [NORM_W-1:0]    cheb_ff;

   // margin: eps * nn / cheb
   logic [EPS_W-1:0]  eps_sh_ff;
   logic [EPW-1:0]    nnsh_ff, prod_ff, qe_ff;
   logic [NORM_W-1:0] rem_ff;

   // plane distances and crossing fraction
   logic signed [DW-1:0] dist_ff, d1_ff, d2_ff;
   logic [DW-1:0]        rf_ff, den_ff;
   logic                 enter_dir_ff;
   logic [FB-1:0]        qf_ff;

   // brush state
   logic signed [FW-1:0]     enter_ff, leave_ff;
   logic signed [NORM_W-1:0] cn_ff [3];
   logic signed [CW-1:0]     coff_ff;
   logic                     started_ff, ended_ff, fully_ff;

   // result build
   logic [FB:0]          frac_ff, fsh_ff;
   logic                 ssolid_ff, asolid_ff, hit_ff;
   logic signed [CW:0]   delta_ff [3];
   logic signed [SW-1:0] sacc_ff [3];

   // output register
   logic                     rsp_valid_ff;
   logic [FB:0]              rsp_frac_ff;
   logic                     rsp_ss_ff, rsp_as_ff;
   logic signed [NORM_W-1:0] rsp_n_ff [3];
   logic signed [CW-1:0]     rsp_d_ff;
   logic signed [CW-1:0]     rsp_stop_ff [3];

   // handshake
   logic req_acc, out_go;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign out_go        = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // axis operand select for the multiplier load
   logic signed [NORM_W-1:0] ld_n;
   logic signed [CW-1:0]     ld_s, ld_e, ld_min, ld_max, ld_corner;
   logic [NORM_W-1:0]        ld_abs;
   always_comb begin
      ld_n   = req_bus.normal_x;
      ld_s   = req_bus.start_x;
      ld_e   = req_bus.end_x;
      ld_min = hmin_ff[0];
      ld_max = hmax_ff[0];
      if (state_ff != ST_IDLE) begin
         case (axis_ff)
            2'd0: begin
               ld_n   = n_ff[1];
               ld_s   = s_ff[1];
               ld_e   = e_ff[1];
               ld_min = hmin_ff[1];
               ld_max = hmax_ff[1];
            end
            default: begin
               ld_n   = n_ff[2];
               ld_s   = s_ff[2];
               ld_e   = e_ff[2];
               ld_min = hmin_ff[2];
               ld_max = hmax_ff[2];
            end
         endcase
      end
      ld_corner = ld_n[NORM_W-1] ? ld_max : ld_min;
      ld_abs    = ld_n[NORM_W-1] ? $unsigned(-ld_n) : $unsigned(ld_n);
   end

   // margin as a signed distance
   logic signed [DW-1:0] ce;
   assign ce = $signed(DW'(qe_ff));

   // divider steps
   logic [NORM_W:0] dive_r2;
   logic            dive_ge;
   assign dive_r2 = {rem_ff, prod_ff[EPW-1]};
   assign dive_ge = dive_r2 >= {1'b0, cheb_ff};

   logic [DW:0] divf_r2;
   logic        divf_ge;
   assign divf_r2 = {rf_ff, 1'b0};
   assign divf_ge = divf_r2 >= {1'b0, den_ff};

   // plane classification
   logic gt1, ge2, le1, le2, d1_gt_d2;
   assign gt1      = d1_ff > ce;
   assign ge2      = d2_ff >= ce;
   assign le1      = !gt1;
   assign le2      = d2_ff <= ce;
   assign d1_gt_d2 = d1_ff > d2_ff;

   logic signed [FW-1:0] f_new;
   assign f_new = $signed({2'b00, qf_ff});

   // final outcome
   logic        ent_hit, fin_ss, fin_as, fin_hit;
   logic [FB:0] fin_frac;
   always_comb begin
      ent_hit  = (enter_ff < leave_ff) && (enter_ff > F_MONE) && (enter_ff < F_ONE);
      fin_ss   = 1'b0;
      fin_as   = 1'b0;
      fin_hit  = 1'b0;
      fin_frac = {1'b1, {FB{1'b0}}};
      if (!fully_ff) begin
         if (!started_ff) begin
            fin_ss = 1'b1;
            if (!ended_ff) begin
               fin_as   = 1'b1;
               fin_frac = '0;
            end
         end else if (ent_hit) begin
            fin_hit  = 1'b1;
            fin_frac = enter_ff[FW-1] ? '0 : enter_ff[FB:0];
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
         for (int a = 0; a < 3; a++) begin
            hmin_ff[a] <= '0;
            hmax_ff[a] <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_EPS:   eps_ff     <= csr_write_data[EPS_W-1:0];
            CSR_MIN_X: hmin_ff[0] <= csr_write_data;
            CSR_MIN_Y: hmin_ff[1] <= csr_write_data;
            CSR_MIN_Z: hmin_ff[2] <= csr_write_data;
            CSR_MAX_X: hmax_ff[0] <= csr_write_data;
            CSR_MAX_Y: hmax_ff[1] <= csr_write_data;
            CSR_MAX_Z: hmax_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer and control state
   state_type state_in;
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc) state_in = fully_ff ? (req_bus.last_plane ? ST_FIN : ST_IDLE)
                                                   : ST_MUL;
         ST_MUL:  if (cnt_ff == CNT_W'(NORM_W - 1) && axis_ff == 2'd2)
                     state_in = (cheb_ff == '0) ? ST_DIST : ST_EPS;
         ST_EPS:  if (cnt_ff == CNT_W'(EPS_W - 1)) state_in = ST_DIVE;
         ST_DIVE: if (cnt_ff == CNT_W'(EPW - 1)) state_in = ST_DIST;
         ST_DIST: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_DEC;
         ST_DEC: begin
            if ((gt1 && ge2) || (le1 && le2)) state_in = last_ff ? ST_FIN : ST_IDLE;
            else                              state_in = ST_DIVF;
         end
         ST_DIVF: if (cnt_ff == CNT_W'(FB - 1)) state_in = ST_UPD;
         ST_UPD:  state_in = last_ff ? ST_FIN : ST_IDLE;
         ST_FIN:  state_in = ST_STOP;
         ST_STOP: if (cnt_ff == CNT_W'(FB)) state_in = ST_OUT;
         ST_OUT:  if (out_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         axis_ff    <= '0;
         cnt_ff     <= '0;
         enter_ff   <= F_MONE;
         leave_ff   <= F_ONE;
         coff_ff    <= '0;
         started_ff <= 1'b0;
         ended_ff   <= 1'b0;
         fully_ff   <= 1'b0;
         for (int a = 0; a < 3; a++) cn_ff[a] <= '0;
      end else begin
         state_ff <= state_in;
         // step counter restarts on every state change and on every new axis
         if (state_in != state_ff ||
             (state_ff == ST_MUL && cnt_ff == CNT_W'(NORM_W - 1))) cnt_ff <= '0;
         else                                                     cnt_ff <= cnt_ff + CNT_W'(1);

         case (state_ff)
            ST_IDLE: axis_ff <= '0;
            ST_MUL: begin
               if (cnt_ff == CNT_W'(NORM_W - 1)) axis_ff <= axis_ff + 2'd1;
            end
            ST_DEC: begin
               if (d2_ff > ce) ended_ff <= 1'b1;
               if (d1_ff > 0)  started_ff <= 1'b1;
               if (gt1 && ge2) fully_ff <= 1'b1;
            end
            ST_UPD: begin
               if (enter_dir_ff) begin
                  if (f_new > enter_ff) begin
                     enter_ff <= f_new;
                     for (int a = 0; a < 3; a++) cn_ff[a] <= n_ff[a];
                     coff_ff <= pd_ff;
                  end
               end else if (f_new < leave_ff) begin
                  leave_ff <= f_new;
               end
            end
            ST_OUT: begin
               // brush done: back to the empty state
               if (out_go) begin
                  enter_ff   <= F_MONE;
                  leave_ff   <= F_ONE;
                  coff_ff    <= '0;
                  started_ff <= 1'b0;
                  ended_ff   <= 1'b0;
                  fully_ff   <= 1'b0;
                  for (int a = 0; a < 3; a++) cn_ff[a] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               s_ff[0] <= req_bus.start_x;
               s_ff[1] <= req_bus.start_y;
               s_ff[2] <= req_bus.start_z;
               e_ff[0] <= req_bus.end_x;
               e_ff[1] <= req_bus.end_y;
               e_ff[2] <= req_bus.end_z;
               n_ff[0] <= req_bus.normal_x;
               n_ff[1] <= req_bus.normal_y;
               n_ff[2] <= req_bus.normal_z;
               pd_ff   <= req_bus.plane_distance;
               last_ff <= req_bus.last_plane;
               nn_ff   <= '0;
               exp_ff  <= '0;
               ds_ff   <= '0;
               de_ff   <= '0;
               cheb_ff <= ld_abs;
               mb_ff   <= ld_n;
               mn_ff   <= DW'(ld_n);
               mc_ff   <= DW'(ld_corner);
               ms_ff   <= DW'(ld_s);
               me_ff   <= DW'(ld_e);
            end
         end
         ST_MUL: begin
            // LSB-first shift-add, sign bit weighs negative
            nn_ff  <= nn_ff  + pp_term(mn_ff, mb_ff[0], cnt_ff == CNT_W'(NORM_W - 1));
            exp_ff <= exp_ff + pp_term(mc_ff, mb_ff[0], cnt_ff == CNT_W'(NORM_W - 1));
            ds_ff  <= ds_ff  + pp_term(ms_ff, mb_ff[0], cnt_ff == CNT_W'(NORM_W - 1));
            de_ff  <= de_ff  + pp_term(me_ff, mb_ff[0], cnt_ff == CNT_W'(NORM_W - 1));
            if (cnt_ff == CNT_W'(NORM_W - 1)) begin
               mb_ff <= ld_n;
               mn_ff <= DW'(ld_n);
               mc_ff <= DW'(ld_corner);
               ms_ff <= DW'(ld_s);
               me_ff <= DW'(ld_e);
               if (axis_ff != 2'd2 && ld_abs > cheb_ff) cheb_ff <= ld_abs;
            end else begin
               mb_ff <= mb_ff >> 1;
               mn_ff <= mn_ff <<< 1;
               mc_ff <= mc_ff <<< 1;
               ms_ff <= ms_ff <<< 1;
               me_ff <= me_ff <<< 1;
            end
            nnsh_ff   <= '0;
            prod_ff   <= '0;
            eps_sh_ff <= eps_ff;
            qe_ff     <= '0;
         end
         ST_EPS: begin
            if (cnt_ff == '0) begin
               if (eps_sh_ff[0]) prod_ff <= EPW'(nn_ff);
               nnsh_ff <= EPW'(nn_ff) << 1;
            end else begin
               if (eps_sh_ff[0]) prod_ff <= prod_ff + nnsh_ff;
               nnsh_ff <= nnsh_ff << 1;
            end
            eps_sh_ff <= eps_sh_ff >> 1;
            rem_ff    <= '0;
         end
         ST_DIVE: begin
            // restoring division, one quotient bit a cycle
            rem_ff  <= dive_ge ? NORM_W'(dive_r2 - {1'b0, cheb_ff}) : dive_r2[NORM_W-1:0];
            qe_ff   <= {qe_ff[EPW-2:0], dive_ge};
            prod_ff <= prod_ff << 1;
         end
         ST_DIST: dist_ff <= (DW'(pd_ff) <<< NORM_FRAC) - exp_ff;
         ST_DIFF: begin
            d1_ff <= ds_ff - dist_ff;
            d2_ff <= de_ff - dist_ff;
         end
         ST_DEC: begin
            enter_dir_ff <= d1_gt_d2;
            rf_ff        <= d1_gt_d2 ? $unsigned(d1_ff - ce) : $unsigned(ce - d1_ff);
            den_ff       <= d1_gt_d2 ? $unsigned(d1_ff - d2_ff) : $unsigned(d2_ff - d1_ff);
            qf_ff        <= '0;
         end
         ST_DIVF: begin
            rf_ff <= divf_ge ? DW'(divf_r2 - {1'b0, den_ff}) : divf_r2[DW-1:0];
            qf_ff <= {qf_ff[FB-2:0], divf_ge};
         end
         ST_FIN: begin
            frac_ff   <= fin_frac;
            fsh_ff    <= fin_frac;
            ssolid_ff <= fin_ss;
            asolid_ff <= fin_as;
            hit_ff    <= fin_hit;
            for (int a = 0; a < 3; a++) begin
               delta_ff[a] <= $signed({e_ff[a][CW-1], e_ff[a]}) -
                              $signed({s_ff[a][CW-1], s_ff[a]});
               sacc_ff[a]  <= '0;
            end
         end
         ST_STOP: begin
            // MSB-first fraction times delta
            for (int a = 0; a < 3; a++)
               sacc_ff[a] <= (sacc_ff[a] <<< 1) + (fsh_ff[FB] ? SW'(delta_ff[a]) : SW'(0));
            fsh_ff <= fsh_ff << 1;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_go) begin
         rsp_frac_ff <= frac_ff;
         rsp_ss_ff   <= ssolid_ff;
         rsp_as_ff   <= asolid_ff;
         rsp_d_ff    <= hit_ff ? coff_ff : '0;
         for (int a = 0; a < 3; a++) begin
            rsp_n_ff[a]    <= hit_ff ? cn_ff[a] : '0;
            rsp_stop_ff[a] <= s_ff[a] + CW'(sacc_ff[a] >>> FB);
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.fraction     = rsp_frac_ff;
   assign rsp_bus.start_solid  = rsp_ss_ff;
   assign rsp_bus.all_solid    = rsp_as_ff;
   assign rsp_bus.hit_normal_x = rsp_n_ff[0];
   assign rsp_bus.hit_normal_y = rsp_n_ff[1];
   assign rsp_bus.hit_normal_z = rsp_n_ff[2];
   assign rsp_bus.hit_distance = rsp_d_ff;
   assign rsp_bus.stop_x       = rsp_stop_ff[0];
   assign rsp_bus.stop_y       = rsp_stop_ff[1];
   assign rsp_bus.stop_z       = rsp_stop_ff[2];

   // checks
   `BSCBC_ASSERT_IMP(a_dive_rem, clock, reset, state_ff == ST_DIVE, rem_ff < cheb_ff)
   `BSCBC_ASSERT_IMP(a_divf_rem, clock, reset, state_ff == ST_DIVF, rf_ff < den_ff)
   `BSCBC_ASSERT_NXT(a_start, clock, reset, req_acc && !fully_ff, state_ff == ST_MUL)
   `BSCBC_ASSERT_NXT(a_out_hold, clock, reset, state_ff == ST_OUT && !out_go, state_ff == ST_OUT)

endmodule

// ----- test/tb.sv -----
module tb;
   import bscbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW        = 24;
   localparam int FB        = 16;
   localparam longint F_ONE = 64'sd1 << FB;
   localparam int WATCHDOG  = 20000;
   localparam int HOLD_LEN  = 3000;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [CW-1:0]     sx, sy, sz, ex, ey, ez;
      logic signed [NORM_W-1:0] nx, ny, nz;
      logic signed [CW-1:0]     pd;
      logic                     last;
   } plane_type;

   typedef struct {
      logic [FB:0]              fraction;
      logic                     ssolid, asolid;
      logic signed [NORM_W-1:0] hnx, hny, hnz;
      logic signed [CW-1:0]     hd, px, py, pz;
   } trace_type;

   typedef struct {
      plane_type p;
      bit        typed;
      trace_type t;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CW-1:0]        csr_write_data = '0;

   bscbc_req_if #(.COORD_WIDTH(CW)) req_bus ();
   bscbc_rsp_if #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) rsp_bus ();

   box_sweep_convex_brush_clip_top #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always #6 clock = ~clock;

   // predictor copy of registers and brush state
   logic [EPS_W-1:0]     m_eps;
   logic signed [CW-1:0] m_min [3];
   logic signed [CW-1:0] m_max [3];
   longint m_enter, m_leave, m_cnorm [3], m_coff;
   bit     m_sout, m_eout, m_fout;

   trace_type     trace_q [$];
   idle_mode_type mode = IDLE_NONE;
   int  errors = 0, mismatches = 0, checked = 0, planes_sent = 0, brushes = 0;
   int  stall_cnt = 0, hold_cnt = 0;
   bit  long_hold_req = 0;

   function automatic void clear_brush();
      m_enter = -F_ONE;
      m_leave = F_ONE;
      for (int a = 0; a < 3; a++) m_cnorm[a] = 0;
      m_coff = 0;
      m_sout = 0;
      m_eout = 0;
      m_fout = 0;
   endfunction

   // truncated num/den, num < den
   function automatic longint crossing_frac(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      for (int i = 0; i < FB; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return longint'(q);
   endfunction

   function automatic longint scaled_delta(longint f, longint delta);
      longint p;
      p = f * delta;
      if (p >= 0) return p >> FB;
      return -(((-p) + (F_ONE - 1)) >> FB);
   endfunction

   // advance the brush by one plane; returns 1 and the trace on the final plane
   function automatic bit clip_plane(input plane_type p, output trace_type t);
      longint s [3], e [3], n [3];
      longint pd, nn, cheb, expand, ds, de, ce, pdist, d1, d2, f, corner, mg, frac, pt;
      bit ss, as, hit;
      s[0] = p.sx; s[1] = p.sy; s[2] = p.sz;
      e[0] = p.ex; e[1] = p.ey; e[2] = p.ez;
      n[0] = p.nx; n[1] = p.ny; n[2] = p.nz;
      pd = p.pd;
      t = '{default: '0};
      if (!m_fout) begin
         nn = 0; cheb = 0; expand = 0; ds = 0; de = 0; ce = 0;
         for (int a = 0; a < 3; a++) begin
            corner = (n[a] < 0) ? longint'(m_max[a]) : longint'(m_min[a]);
            nn += n[a] * n[a];
            mg = (n[a] < 0) ? -n[a] : n[a];
            if (mg > cheb) cheb = mg;
            expand += corner * n[a];
            ds += s[a] * n[a];
            de += e[a] * n[a];
         end
         if (cheb > 0) ce = (longint'(m_eps) * nn) / cheb;
         pdist = pd * (64'sd1 << NORM_FRAC) - expand;
         d1 = ds - pdist;
         d2 = de - pdist;
         if (d2 > ce) m_eout = 1;
         if (d1 > 0) m_sout = 1;
         if (d1 > ce && d2 >= ce) begin
            m_fout = 1;
         end else if (!(d1 <= ce && d2 <= ce)) begin
            if (d1 > d2) begin
               f = crossing_frac(d1 - ce, d1 - d2);
               if (f > m_enter) begin
                  m_enter = f;
                  for (int a = 0; a < 3; a++) m_cnorm[a] = n[a];
                  m_coff = pd;
               end
            end else begin
               f = crossing_frac(ce - d1, d2 - d1);
               if (f < m_leave) m_leave = f;
            end
         end
      end
      if (!p.last) return 0;
      frac = F_ONE;
      ss = 0; as = 0; hit = 0;
      if (!m_fout) begin
         if (!m_sout) begin
            ss = 1;
            if (!m_eout) begin
               as = 1;
               frac = 0;
            end
         end else if (m_enter < m_leave && m_enter > -F_ONE && m_enter < F_ONE) begin
            frac = (m_enter < 0) ? 0 : m_enter;
            hit = 1;
         end
      end
      t.fraction = frac[FB:0];
      t.ssolid = ss;
      t.asolid = as;
      if (hit) begin
         t.hnx = m_cnorm[0][NORM_W-1:0];
         t.hny = m_cnorm[1][NORM_W-1:0];
         t.hnz = m_cnorm[2][NORM_W-1:0];
         t.hd  = m_coff[CW-1:0];
      end
      pt = (frac == F_ONE) ? e[0] : s[0] + scaled_delta(frac, e[0] - s[0]);
      t.px = pt[CW-1:0];
      pt = (frac == F_ONE) ? e[1] : s[1] + scaled_delta(frac, e[1] - s[1]);
      t.py = pt[CW-1:0];
      pt = (frac == F_ONE) ? e[2] : s[2] + scaled_delta(frac, e[2] - s[2]);
      t.pz = pt[CW-1:0];
      clear_brush();
      return 1;
   endfunction

   task automatic csr_write(csr_index_type idx, logic [CW-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_EPS:   m_eps = data[EPS_W-1:0];
         CSR_MIN_X: m_min[0] = data;
         CSR_MIN_Y: m_min[1] = data;
         CSR_MIN_Z: m_min[2] = data;
         CSR_MAX_X: m_max[0] = data;
         CSR_MAX_Y: m_max[1] = data;
         CSR_MAX_Z: m_max[2] = data;
         default: ;
      endcase
   endtask

   task automatic set_hull(int eps, int x0, int y0, int z0, int x1, int y1, int z1);
      csr_write(CSR_EPS, CW'(eps));
      csr_write(CSR_MIN_X, CW'(x0));
      csr_write(CSR_MIN_Y, CW'(y0));
      csr_write(CSR_MIN_Z, CW'(z0));
      csr_write(CSR_MAX_X, CW'(x1));
      csr_write(CSR_MAX_Y, CW'(y1));
      csr_write(CSR_MAX_Z, CW'(z1));
   endtask

   // present one plane request and hold it until accepted; valid stays high after
   task automatic send_plane(plane_type p, bit typed, trace_type typed_t);
      trace_type t;
      while ((mode == IDLE_SEND && $urandom_range(99) < 58) ||
             (mode == IDLE_BOTH && $urandom_range(99) < 28)) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.start_x = p.sx; req_bus.start_y = p.sy; req_bus.start_z = p.sz;
      req_bus.end_x = p.ex; req_bus.end_y = p.ey; req_bus.end_z = p.ez;
      req_bus.normal_x = p.nx; req_bus.normal_y = p.ny; req_bus.normal_z = p.nz;
      req_bus.plane_distance = p.pd;
      req_bus.last_plane = p.last;
      do @(posedge clock); while (!req_bus.ready);
      planes_sent++;
      if (clip_plane(p, t)) begin
         brushes++;
         trace_q.push_back(typed ? typed_t : t);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (trace_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic int rsmall(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   function automatic plane_type row(int sx, int sy, int sz, int ex, int ey, int ez,
                                     int nx, int ny, int nz, int pd, bit last);
      plane_type p;
      p.sx = CW'(sx); p.sy = CW'(sy); p.sz = CW'(sz);
      p.ex = CW'(ex); p.ey = CW'(ey); p.ez = CW'(ez);
      p.nx = NORM_W'(nx); p.ny = NORM_W'(ny); p.nz = NORM_W'(nz);
      p.pd = CW'(pd); p.last = last;
      return p;
   endfunction

   function automatic trace_type tr(int f, bit ss, bit as, int px, int py, int pz);
      trace_type t;
      t = '{default: '0};
      t.fraction = (FB + 1)'(f); t.ssolid = ss; t.asolid = as;
      t.px = CW'(px); t.py = CW'(py); t.pz = CW'(pz);
      return t;
   endfunction

   // one random brush: mostly a box of axis planes with slanted extras, some noise
   task automatic send_brush(output int count);
      plane_type p, base;
      int cx, cy, cz, h, np, kind;
      trace_type nul;
      nul = '{default: '0};
      kind = $urandom_range(99);
      np = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
      cx = rsmall(2000); cy = rsmall(2000); cz = rsmall(2000);
      h = $urandom_range(100, 3000);
      base = row(rsmall(6000), rsmall(6000), rsmall(6000),
                 rsmall(6000), rsmall(6000), rsmall(6000), 0, 0, 0, 0, 0);
      count = np;
      for (int i = 0; i < np; i++) begin
         p = base;
         if (kind < 12) begin
            p = row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, 0);
         end else begin
            if ($urandom_range(9) == 0) begin
               p.ex = CW'(rsmall(6000)); p.ey = CW'(rsmall(6000)); p.ez = CW'(rsmall(6000));
            end
            case ($urandom_range(7))
               0: begin p.nx = 16'sd16384;  p.ny = '0; p.nz = '0; p.pd = CW'(cx + h); end
               1: begin p.nx = -16'sd16384; p.ny = '0; p.nz = '0; p.pd = CW'(h - cx); end
               2: begin p.ny = 16'sd16384;  p.nx = '0; p.nz = '0; p.pd = CW'(cy + h); end
               3: begin p.ny = -16'sd16384; p.nx = '0; p.nz = '0; p.pd = CW'(h - cy); end
               4: begin p.nz = 16'sd16384;  p.nx = '0; p.ny = '0; p.pd = CW'(cz + h); end
               5: begin p.nz = -16'sd16384; p.nx = '0; p.ny = '0; p.pd = CW'(h - cz); end
               default: begin
                  p.nx = NORM_W'(rsmall(16384));
                  p.ny = NORM_W'(rsmall(16384));
                  p.nz = NORM_W'(rsmall(16384));
                  p.pd = CW'(rsmall(4000));
               end
            endcase
         end
         p.last = (i == np - 1);
         send_plane(p, 0, nul);
      end
   endtask

   task automatic random_phase(idle_mode_type m, int target, bit with_hold);
      int n, c;
      mode = m;
      n = 0;
      while (n < target) begin
         send_brush(c);
         n += c;
         if (with_hold && n > 20) begin
            long_hold_req = 1;
            with_hold = 0;
         end
      end
      drain();
   endtask

   // receiver: random stalls, with one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 0;
         hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_bus.ready = 1'b0;
      end else if (mode == IDLE_RECV) begin
         rsp_bus.ready = ($urandom_range(99) >= 58);
      end else if (mode == IDLE_BOTH) begin
         rsp_bus.ready = ($urandom_range(99) >= 28);
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   initial rsp_bus.ready = 1'b0;

   // result check and watchdog
   always @(posedge clock) begin
      trace_type exp_t, got;
      bit bad;
      if (!reset) begin
         stall_cnt++;
         if (req_bus.valid && req_bus.ready) stall_cnt = 0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            stall_cnt = 0;
            got.fraction = rsp_bus.fraction;
            got.ssolid = rsp_bus.start_solid;
            got.asolid = rsp_bus.all_solid;
            got.hnx = rsp_bus.hit_normal_x;
            got.hny = rsp_bus.hit_normal_y;
            got.hnz = rsp_bus.hit_normal_z;
            got.hd = rsp_bus.hit_distance;
            got.px = rsp_bus.stop_x;
            got.py = rsp_bus.stop_y;
            got.pz = rsp_bus.stop_z;
            if (trace_q.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected result at %0t", $realtime);
            end else begin
               exp_t = trace_q.pop_front();
               checked++;
               bad = (got.fraction !== exp_t.fraction) || (got.ssolid !== exp_t.ssolid) ||
                     (got.asolid !== exp_t.asolid) || (got.hnx !== exp_t.hnx) ||
                     (got.hny !== exp_t.hny) || (got.hnz !== exp_t.hnz) ||
                     (got.hd !== exp_t.hd) || (got.px !== exp_t.px) ||
                     (got.py !== exp_t.py) || (got.pz !== exp_t.pz);
               if (bad) begin
                  errors++;
                  if (mismatches++ < 10) begin
                     $display("mismatch %0d: exp frac=%0d ss=%0b as=%0b n=%0d,%0d,%0d d=%0d stop=%0d,%0d,%0d",
                              checked, exp_t.fraction, exp_t.ssolid, exp_t.asolid, exp_t.hnx,
                              exp_t.hny, exp_t.hnz, exp_t.hd, exp_t.px, exp_t.py, exp_t.pz);
                     $display("          got frac=%0d ss=%0b as=%0b n=%0d,%0d,%0d d=%0d stop=%0d,%0d,%0d",
                              got.fraction, got.ssolid, got.asolid, got.hnx, got.hny,
                              got.hnz, got.hd, got.px, got.py, got.pz);
                  end
               end
            end
         end
         if (stall_cnt >= WATCHDOG) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG);
            $display("FAIL");
            $finish;
         end
      end
   end

   stim_row_type dir_rows [$];

   initial begin
      trace_type nul;
      nul = '{default: '0};
      req_bus.valid = 1'b0;
      req_bus.start_x = '0; req_bus.start_y = '0; req_bus.start_z = '0;
      req_bus.end_x = '0; req_bus.end_y = '0; req_bus.end_z = '0;
      req_bus.normal_x = '0; req_bus.normal_y = '0; req_bus.normal_z = '0;
      req_bus.plane_distance = '0;
      req_bus.last_plane = 1'b0;
      m_eps = EPS_RESET;
      for (int a = 0; a < 3; a++) begin
         m_min[a] = '0;
         m_max[a] = '0;
      end
      clear_brush();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows, reset registers
      // start and end both behind the plane: all solid, stop at start
      dir_rows.push_back('{row(-256, 5, 6, -256, 7, 8, 16384, 0, 0, 0, 1), 1,
                           tr(0, 1, 1, -256, 5, 6)});
      // plane fully in front: no hit, stop at end
      dir_rows.push_back('{row(256, 1, 2, 256, 3, 4, 16384, 0, 0, 0, 1), 1,
                           tr(65536, 0, 0, 256, 3, 4)});
      // start inside, end outside
      dir_rows.push_back('{row(-256, 0, 0, 512, 0, 0, 16384, 0, 0, 0, 1), 1,
                           tr(65536, 1, 0, 512, 0, 0)});
      // zero normal
      dir_rows.push_back('{row(10, 20, 30, -40, 50, 60, 0, 0, 0, 100, 1), 0, nul});
      // box brush hit from outside
      dir_rows.push_back('{row(-2000, 0, 0, 2000, 0, 0, -16384, 0, 0, 500, 0), 0, nul});
      dir_rows.push_back('{row(-2000, 0, 0, 2000, 0, 0, 16384, 0, 0, 500, 0), 0, nul});
      dir_rows.push_back('{row(-2000, 0, 0, 2000, 0, 0, 0, 16384, 0, 500, 0), 0, nul});
      dir_rows.push_back('{row(-2000, 0, 0, 2000, 0, 0, 0, -16384, 0, 500, 1), 0, nul});
      // entry crossing, then a plane with the whole segment in front
      dir_rows.push_back('{row(-2000, 0, 0, 2000, 1000, 0, -16384, 0, 0, 500, 0), 0, nul});
      dir_rows.push_back('{row(-2000, 0, 0, 2000, 1000, 0, 0, 16384, 0, -1500, 1), 0, nul});
      // later planes ignored after fully in front
      dir_rows.push_back('{row(0, 0, 0, 0, 0, 0, 0, 0, -16384, -100, 0), 0, nul});
      dir_rows.push_back('{row(0, 0, 0, 0, 0, 0, 16384, 0, 0, 100, 1), 0, nul});
      // field extremes
      dir_rows.push_back('{row(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                               -16384, 16384, -16384, 8388607, 0), 0, nul});
      dir_rows.push_back('{row(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
                               16384, -16384, 16384, -8388608, 1), 0, nul});
      dir_rows.push_back('{row(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1), 0, nul});
      mode = IDLE_NONE;
      foreach (dir_rows[i]) send_plane(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].t);
      drain();

      // random phases over several register settings and idle modes
      random_phase(IDLE_NONE, 250, 0);
      set_hull(0, -256, -128, -64, 256, 128, 64);
      random_phase(IDLE_SEND, 300, 0);
      set_hull(65535, 200, 300, -400, 100, 600, -300);
      random_phase(IDLE_RECV, 300, 1);
      set_hull($urandom_range(65535), -rsmall(500) - 500, -400, -300, 500, 400, 300);
      random_phase(IDLE_BOTH, 300, 0);
      set_hull(65535, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
      random_phase(IDLE_SEND, 150, 0);
      set_hull(8, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
      random_phase(IDLE_RECV, 150, 0);
      set_hull($urandom_range(40), -$urandom_range(1000), -$urandom_range(1000),
               -$urandom_range(1000), $urandom_range(1000), $urandom_range(1000),
               $urandom_range(1000));
      random_phase(IDLE_BOTH, 300, 0);

      $display("covered %0d planes in %0d brushes, %0d results checked", planes_sent,
               brushes, checked);
      $display("idle modes: none, sender, receiver, both; one long receiver hold-off");
      if (errors == 0 && trace_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
